>>> hdl/padding_delay_parse_and_pad_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the padding delay parser
// Shared forms for the concurrent checks of this block.
// ----------------------------------------------------------------------------
`ifndef PADDING_DELAY_PARSE_AND_PAD_ASSERT_SVH
`define PADDING_DELAY_PARSE_AND_PAD_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PDPP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PDPP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/pdpp_pkg.sv
// ----------------------------------------------------------------------------
// pdpp_pkg
// Types, constants and the character time table of the padding delay parser.
// ----------------------------------------------------------------------------
package pdpp_pkg;

	// Character codes of the delay prefix.
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_POINT = 8'h2E;

	localparam int DELAY_W = 16;
	localparam int SPEED_W = 4;
	localparam logic [SPEED_W-1:0] SPEED_RESET = 4'd14;

	// Divider sizes: dividend is delay plus half a character time.
	localparam int DIV_W = DELAY_W + 1;
	localparam int REM_W = 11;
	localparam int CNT_W = $clog2(DIV_W + 1);

	// Default depth of the queue between parser and pad generator.
	localparam int QUEUE_DEPTH = 4;

	// One classified item handed from the parser to the back end.
	typedef struct packed {
		logic                is_end;
		logic                body;
		logic [7:0]          ch;
		logic [DELAY_W-1:0]  delay;
	} pdpp_item_t;

	// Time of one character in tenths of a millisecond per line speed code.
	function automatic logic [REM_W-1:0] char_time(input logic [SPEED_W-1:0] code);
		logic [REM_W-1:0] t;
		case (code)
			4'd0:    t = 11'd0;
			4'd1:    t = 11'd2000;
			4'd2:    t = 11'd1333;
			4'd3:    t = 11'd909;
			4'd4:    t = 11'd743;
			4'd5:    t = 11'd666;
			4'd6:    t = 11'd500;
			4'd7:    t = 11'd333;
			4'd8:    t = 11'd166;
			4'd9:    t = 11'd83;
			4'd10:   t = 11'd55;
			4'd11:   t = 11'd41;
			4'd12:   t = 11'd20;
			4'd13:   t = 11'd10;
			4'd14:   t = 11'd5;
			4'd15:   t = 11'd2;
			default: t = 11'd0;
		endcase
		return t;
	endfunction

endpackage

>>> hdl/pdpp_front.sv
// ----------------------------------------------------------------------------
// pdpp_front
// Parses the delay prefix and classifies each incoming item.
// ----------------------------------------------------------------------------
module pdpp_front import pdpp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_ch,
	input  logic       in_end,
	output logic       push,
	input  logic       push_ready,
	output pdpp_item_t push_item
);

	localparam logic [1:0] PH_INT   = 2'd0;
	localparam logic [1:0] PH_FRAC1 = 2'd1;
	localparam logic [1:0] PH_SKIP  = 2'd2;
	localparam logic [1:0] PH_BODY  = 2'd3;

	logic [1:0]         phase_q, phase_d;
	logic [DELAY_W-1:0] delay_q, delay_d;
	logic               is_dec;
	logic [3:0]         dig;
	logic [19:0]        int_sum;
	logic [DELAY_W:0]   frac_sum;
	logic               body;

	assign in_ready = push_ready;
	assign push     = in_valid && push_ready;

	// Digit decode and the two saturating accumulations.
	always_comb begin
		is_dec   = (in_ch >= CHAR_ZERO) && (in_ch <= CHAR_ZERO + 8'd9);
		dig      = 4'(in_ch - CHAR_ZERO);
		int_sum  = {1'b0, delay_q, 3'b000} + {3'b000, delay_q, 1'b0}
		         + {13'd0, dig, 3'b000} + {15'd0, dig, 1'b0};
		frac_sum = {1'b0, delay_q} + {13'd0, dig};
	end

	// Next phase and delay, and whether the character belongs to the body.
	always_comb begin
		phase_d = phase_q;
		delay_d = delay_q;
		body    = 1'b0;
		if (in_end) begin
			phase_d = PH_INT;
			delay_d = '0;
		end else begin
			case (phase_q)
				PH_INT: begin
					if (is_dec) begin
						delay_d = (int_sum[19:16] != 4'd0) ? {DELAY_W{1'b1}} : int_sum[15:0];
					end else if (in_ch == CHAR_POINT) begin
						phase_d = PH_FRAC1;
					end else begin
						phase_d = PH_BODY;
						body    = 1'b1;
					end
				end
				PH_FRAC1: begin
					if (is_dec) begin
						delay_d = frac_sum[DELAY_W] ? {DELAY_W{1'b1}} : frac_sum[DELAY_W-1:0];
						phase_d = PH_SKIP;
					end else begin
						phase_d = PH_BODY;
						body    = 1'b1;
					end
				end
				PH_SKIP: begin
					if (!is_dec) begin
						phase_d = PH_BODY;
						body    = 1'b1;
					end
				end
				default: begin
					body = 1'b1;
				end
			endcase
		end
	end

	// The terminator carries the delay parsed so far.
	always_comb begin
		push_item.is_end = in_end;
		push_item.body   = body;
		push_item.ch     = in_ch;
		push_item.delay  = delay_q;
	end

	// Parser state advances on every accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_INT;
			delay_q <= '0;
		end else if (push) begin
			phase_q <= phase_d;
			delay_q <= delay_d;
		end
	end

endmodule

>>> hdl/pdpp_queue.sv
// ----------------------------------------------------------------------------
// pdpp_queue
// Short first-in first-out queue of classified items.
// ----------------------------------------------------------------------------
module pdpp_queue import pdpp_pkg::*; #(
	parameter int Depth = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       push_ready,
	input  pdpp_item_t push_item,
	input  logic       pop,
	output logic       head_valid,
	output pdpp_item_t head_item
);

	localparam int PtrW   = $clog2(Depth);
	localparam int CountW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0]   LastPtr   = PtrW'(Depth - 1);
	localparam logic [CountW-1:0] FullCount = CountW'(Depth);

	pdpp_item_t        entries_q [Depth];
	logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CountW-1:0] count_q;

	assign push_ready = (count_q != FullCount);
	assign head_valid = (count_q != '0);
	assign head_item  = entries_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Item storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> hdl/pdpp_back.sv
// ----------------------------------------------------------------------------
// pdpp_back
// Emits results and divides the delay by the character time on terminators.
// ----------------------------------------------------------------------------
module pdpp_back import pdpp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [SPEED_W-1:0] speed_code,
	input  logic               head_valid,
	input  pdpp_item_t         head_item,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               out_char_valid,
	output logic [7:0]         out_char,
	output logic [DELAY_W-1:0] out_pads,
	output logic               out_done
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DIV  = 1'b1;

	logic               state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DIV_W-1:0]   quot_q;
	logic [REM_W-1:0]   rem_q;
	logic [REM_W-1:0]   t;
	logic [DIV_W-1:0]   dividend;
	logic               no_pad;
	logic               needs_div;
	logic               out_free;
	logic               load_head;
	logic               load_div;
	logic               start_div;
	logic [REM_W:0]     trial;
	logic               fits;

	logic               out_valid_q;
	logic               char_valid_q;
	logic [7:0]         char_q;
	logic [DELAY_W-1:0] pads_q;
	logic               done_q;

	// Operand setup and the handshake decisions.
	always_comb begin
		t         = char_time(speed_code);
		dividend  = {1'b0, head_item.delay} + DIV_W'(t >> 1);
		no_pad    = (head_item.delay == '0) || (t == '0);
		needs_div = head_item.is_end && !no_pad;
		out_free  = !out_valid_q || out_ready;
		load_head = (state_q == ST_IDLE) && head_valid && out_free && !needs_div;
		start_div = (state_q == ST_IDLE) && head_valid && needs_div;
		load_div  = (state_q == ST_DIV) && (cnt_q == '0) && out_free;
		pop       = load_head || start_div;
	end

	// One restoring division step.
	always_comb begin
		trial = {rem_q, quot_q[DIV_W-1]};
		fits  = (trial >= {1'b0, t});
	end

	// Divider control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start_div) begin
						state_q <= ST_DIV;
						cnt_q   <= CNT_W'(DIV_W);
					end
				end
				ST_DIV: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - 1'b1;
					end else if (load_div) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Divider datapath: quotient bits shift in as the dividend shifts out.
	always_ff @(posedge clk) begin
		if (start_div) begin
			quot_q <= dividend;
			rem_q  <= '0;
		end else if ((state_q == ST_DIV) && (cnt_q != '0)) begin
			quot_q <= {quot_q[DIV_W-2:0], fits};
			rem_q  <= fits ? REM_W'(trial - {1'b0, t}) : trial[REM_W-1:0];
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_head || load_div) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load_head) begin
			char_valid_q <= head_item.body;
			char_q       <= head_item.body ? head_item.ch : 8'd0;
			pads_q       <= '0;
			done_q       <= head_item.is_end;
		end else if (load_div) begin
			char_valid_q <= 1'b0;
			char_q       <= 8'd0;
			pads_q       <= quot_q[DELAY_W-1:0];
			done_q       <= 1'b1;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_char_valid = char_valid_q;
	assign out_char       = char_q;
	assign out_pads       = pads_q;
	assign out_done       = done_q;

endmodule

>>> hdl/padding_delay_parse_and_pad.sv
// A character item passes the queue and the output register before it shows;
// a terminator that needs padding passes the queue, divider and output register.
// Throughput: one character per cycle when not stalled by a full queue or output;
// a terminator holds the pad generator busy through the one-bit-per-cycle divider of 17 steps.
// Reset clears the parser, the queue and the output valid flag and sets the
// line speed code to 14.
// ----------------------------------------------------------------------------
// padding_delay_parse_and_pad
// Delay prefix parser and pad count generator for capability strings.
// ----------------------------------------------------------------------------
module padding_delay_parse_and_pad import pdpp_pkg::*; #(
	parameter int QueueDepth = QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration: line speed code.
	input  logic               cfg_wr_en,
	input  logic [SPEED_W-1:0] cfg_wr_data,
	// Input items.
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] ch
	input  logic               s_tlast,   // is_end
	// Result items.
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [23:0]        m_tdata,   // [7:0] out_char, [23:8] pad_nulls
	output logic               m_tuser,   // char_valid
	output logic               m_tlast    // done_res
);

	logic [SPEED_W-1:0] speed_q;
	logic               push;
	logic               push_ready;
	pdpp_item_t         push_item;
	logic               pop;
	logic               head_valid;
	pdpp_item_t         head_item;
	logic [7:0]         out_char;
	logic [DELAY_W-1:0] out_pads;

	// Line speed register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= SPEED_RESET;
		end else if (cfg_wr_en) begin
			speed_q <= cfg_wr_data;
		end
	end

	pdpp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_ch      (s_tdata),
		.in_end     (s_tlast),
		.push       (push),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	pdpp_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	pdpp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.speed_code     (speed_q),
		.head_valid     (head_valid),
		.head_item      (head_item),
		.pop            (pop),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_char_valid (m_tuser),
		.out_char       (out_char),
		.out_pads       (out_pads),
		.out_done       (m_tlast)
	);

	assign m_tdata = {out_pads, out_char};

endmodule

>>> hdl/pdpp_checker.sv
// ----------------------------------------------------------------------------
// pdpp_checker
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "padding_delay_parse_and_pad_assert.svh"

module pdpp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// A stalled result keeps its contents.
	`PDPP_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

	// A body character never carries a pad count.
	`PDPP_ASSERT_NOW(a_body_no_pad, m_tvalid && m_tuser, (m_tdata[23:8] == 16'd0) && !m_tlast, "body character with pad count")

	// A result that is not a body character shows no character.
	`PDPP_ASSERT_NOW(a_char_zero, m_tvalid && !m_tuser, m_tdata[7:0] == 8'd0, "non-body result shows a character")

	// The pad count never exceeds a saturated delay over the shortest time.
	`PDPP_ASSERT_NOW(a_pad_range, m_tvalid, m_tdata[23:8] <= 16'd32768, "pad count out of range")

endmodule

bind padding_delay_parse_and_pad pdpp_checker u_pdpp_checker (.*);
